// ===== design/skvt_pkg.sv =====
// skvt_pkg: shared types and constants for the small key-value table
// holds the table size, derived index widths, operation and status codes
// and the request and response word structs; no dependencies
package skvt_pkg;

  // table size and derived widths
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 5;
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned DATA_W   = 64;

  // operation codes
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_SET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // request word
  typedef struct packed {
    op_e               operation;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  position;
  } req_t;

  // response word
  typedef struct packed {
    status_e           status;
    logic [KEY_W-1:0]  key_out;
    logic [DATA_W-1:0] data_out;
    logic [POS_W-1:0]  next_position;
    logic [POS_W-1:0]  entry_count;
  } rsp_t;

endpackage

// ===== design/small_key_value_table.sv =====
// small_key_value_table: packed key-value table searched by linear scan
// keys and values sit in two synchronous memories driven by one sequencer
// depends on skvt_pkg for sizes, codes and the request and response structs
//
// Usage: drive req_i and raise start while busy is low; the word is taken at
// that clock edge. One response word per request appears on rsp_o for exactly
// one cycle, marked by done_o. The receiver cannot stall; busy stays high
// until the response is issued, and a new request may be taken in the cycle
// that done_o is high.
// Lookup, set and remove scan the key memory one entry per cycle through its
// single read port, pipelined against the compare, and stop at the first
// match or after the last used entry; remove then reads the last entry and
// moves it into the freed slot. Read at position reads both memories at
// that position, or answers without a memory read when the position is past
// the end. One request is in work at a time.
// Reset clears the entry count and the sequencer only; memory contents are
// never read before they are written.
module small_key_value_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  skvt_pkg::req_t req_i,
  output logic          done_o,
  output skvt_pkg::rsp_t rsp_o
);

  // sequencer state codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_RDLAST = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_RDPOS  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [skvt_pkg::CNT_W-1:0] used_q, used_d;
  logic [skvt_pkg::CNT_W-1:0] iss_q, iss_d;
  logic pend_q, pend_d;
  logic [skvt_pkg::IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic [skvt_pkg::IDX_W-1:0] slot_q, slot_d;
  skvt_pkg::req_t req_q;
  skvt_pkg::rsp_t rsp_q, rsp_d;
  logic done_q, done_d;

  // memory ports
  logic [skvt_pkg::KEY_W-1:0]  key_mem [skvt_pkg::CAPACITY];
  logic [skvt_pkg::DATA_W-1:0] val_mem [skvt_pkg::CAPACITY];
  logic rd_en;
  logic [skvt_pkg::IDX_W-1:0] rd_addr;
  logic [skvt_pkg::KEY_W-1:0]  key_rd_q;
  logic [skvt_pkg::DATA_W-1:0] val_rd_q;
  logic key_we, val_we;
  logic [skvt_pkg::IDX_W-1:0] wr_addr;
  logic [skvt_pkg::KEY_W-1:0]  wr_key;
  logic [skvt_pkg::DATA_W-1:0] wr_val;

  logic accept;
  logic hit, exhausted;
  logic [skvt_pkg::CMP_W-1:0] pos_ext, used_ext;
  logic [skvt_pkg::CNT_W-1:0] last_cnt;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign pos_ext  = skvt_pkg::CMP_W'(req_i.position);
  assign used_ext = skvt_pkg::CMP_W'(used_q);
  assign last_cnt = used_q - skvt_pkg::CNT_W'(1);
  assign hit       = pend_q && (key_rd_q == req_q.key);
  assign exhausted = !pend_q && (iss_q >= used_q);

  // key memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[rd_addr];
    end
  end

  // value memory, read at the same address as the keys
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (rd_en) begin
      val_rd_q <= val_mem[rd_addr];
    end
  end

  // sequencer next state and memory control
  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    iss_d      = iss_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    slot_d     = slot_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    key_we     = 1'b0;
    val_we     = 1'b0;
    wr_addr    = '0;
    wr_key     = req_q.key;
    wr_val     = req_q.data;
    done_d     = 1'b0;
    rsp_d.status        = skvt_pkg::ST_OK;
    rsp_d.key_out       = '0;
    rsp_d.data_out      = '0;
    rsp_d.next_position = '0;
    rsp_d.entry_count   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.operation == skvt_pkg::OP_READ) begin
            if (pos_ext < used_ext) begin
              rd_en   = 1'b1;
              rd_addr = pos_ext[skvt_pkg::IDX_W-1:0];
              state_d = S_RDPOS;
            end else begin
              // past the end: answer at once
              done_d              = 1'b1;
              rsp_d.status        = skvt_pkg::ST_NOT_FOUND;
              rsp_d.next_position = req_i.position;
            end
          end else begin
            iss_d   = '0;
            pend_d  = 1'b0;
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          unique case (req_q.operation)
            skvt_pkg::OP_LOOKUP, skvt_pkg::OP_READ: begin
              done_d         = 1'b1;
              rsp_d.data_out = val_rd_q;
              state_d        = S_IDLE;
            end
            skvt_pkg::OP_SET: begin
              // overwrite the value in place
              val_we  = 1'b1;
              wr_addr = pend_idx_q;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
            skvt_pkg::OP_REMOVE: begin
              slot_d  = pend_idx_q;
              state_d = S_RDLAST;
            end
          endcase
        end else if (exhausted) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (req_q.operation == skvt_pkg::OP_SET) begin
            if (used_q >= skvt_pkg::CNT_W'(skvt_pkg::CAPACITY)) begin
              rsp_d.status = skvt_pkg::ST_FULL;
            end else begin
              // append at the end
              key_we  = 1'b1;
              val_we  = 1'b1;
              wr_addr = used_q[skvt_pkg::IDX_W-1:0];
              used_d  = used_q + skvt_pkg::CNT_W'(1);
            end
          end else begin
            rsp_d.status = skvt_pkg::ST_NOT_FOUND;
          end
        end else begin
          // issue the next key read while the previous one is compared
          if (iss_q < used_q) begin
            rd_en      = 1'b1;
            rd_addr    = iss_q[skvt_pkg::IDX_W-1:0];
            iss_d      = iss_q + skvt_pkg::CNT_W'(1);
            pend_d     = 1'b1;
            pend_idx_d = iss_q[skvt_pkg::IDX_W-1:0];
          end else begin
            pend_d = 1'b0;
          end
        end
      end

      S_RDLAST: begin
        rd_en   = 1'b1;
        rd_addr = last_cnt[skvt_pkg::IDX_W-1:0];
        state_d = S_MOVE;
      end

      S_MOVE: begin
        // last entry fills the freed slot
        key_we  = 1'b1;
        val_we  = 1'b1;
        wr_addr = slot_q;
        wr_key  = key_rd_q;
        wr_val  = val_rd_q;
        used_d  = last_cnt;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      S_RDPOS: begin
        done_d              = 1'b1;
        rsp_d.key_out       = key_rd_q;
        rsp_d.data_out      = val_rd_q;
        rsp_d.next_position = req_q.position + skvt_pkg::POS_W'(1);
        state_d             = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_d.entry_count = skvt_pkg::POS_W'(used_d);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      iss_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (done_d) begin
      rsp_q <= rsp_d;
    end
    pend_idx_q <= pend_idx_d;
    slot_q     <= slot_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef ASSERT_OFF
  // entry count never exceeds the table size
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= skvt_pkg::CNT_W'(skvt_pkg::CAPACITY))
    else $error("entry count above capacity");

  // a response is issued only as the sequencer returns to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == S_IDLE))
    else $error("response while sequencer busy");

  // the entry count changes only together with a response
  a_count_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(used_q) |-> done_o)
    else $error("entry count changed without a response");

  // an accepted word either goes busy or answers in the next cycle
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted word dropped");

  // the slot being refilled by remove holds a live entry
  a_move_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE) |-> (skvt_pkg::CNT_W'(slot_q) < used_q))
    else $error("remove slot outside live entries");
`endif

endmodule

// ===== tb/sv/small_key_value_table_test.sv =====
`timescale 1ns / 1ps
// small_key_value_table_test: self-checking testbench for the key-value table
// a scoreboard class shadows the table contents and checks every response word
// depends on skvt_pkg and small_key_value_table
module small_key_value_table_test;

  localparam int unsigned ITEM_TARGET = 1350;
  localparam int unsigned POOL_N      = 24;
  localparam int unsigned END_WAIT    = 24;
  localparam int unsigned IDLE_LIMIT  = 2000;

  // shadow copy of the table and the response words it predicts
  class kv_table_shadow;
    logic [skvt_pkg::KEY_W-1:0]  keys [skvt_pkg::CAPACITY];
    logic [skvt_pkg::DATA_W-1:0] vals [skvt_pkg::CAPACITY];
    int unsigned                 used;
    skvt_pkg::rsp_t              pending_rsp [$];
    int unsigned                 errors;
    int unsigned                 reports;

    function new();
      used    = 0;
      errors  = 0;
      reports = 0;
    endfunction

    // first slot holding the key, or used when absent
    function int unsigned find_slot(logic [skvt_pkg::KEY_W-1:0] k);
      for (int unsigned i = 0; i < used; i++) begin
        if (keys[i] == k) return i;
      end
      return used;
    endfunction

    // apply an accepted request word and queue the response it must produce
    function void note_request(skvt_pkg::req_t rq);
      skvt_pkg::rsp_t rs;
      int unsigned    slot;
      rs        = '0;
      rs.status = skvt_pkg::ST_OK;
      slot      = find_slot(rq.key);
      case (rq.operation)
        skvt_pkg::OP_LOOKUP: begin
          if (slot < used) rs.data_out = vals[slot];
          else rs.status = skvt_pkg::ST_NOT_FOUND;
        end
        skvt_pkg::OP_SET: begin
          if (slot < used) begin
            vals[slot] = rq.data;
          end else if (used >= skvt_pkg::CAPACITY) begin
            rs.status = skvt_pkg::ST_FULL;
          end else begin
            keys[used] = rq.key;
            vals[used] = rq.data;
            used++;
          end
        end
        skvt_pkg::OP_REMOVE: begin
          // last entry fills the freed slot
          if (slot < used) begin
            keys[slot] = keys[used-1];
            vals[slot] = vals[used-1];
            used--;
          end else begin
            rs.status = skvt_pkg::ST_NOT_FOUND;
          end
        end
        default: begin
          if (rq.position < used) begin
            rs.key_out       = keys[rq.position];
            rs.data_out      = vals[rq.position];
            rs.next_position = rq.position + skvt_pkg::POS_W'(1);
          end else begin
            rs.status        = skvt_pkg::ST_NOT_FOUND;
            rs.next_position = rq.position;
          end
        end
      endcase
      rs.entry_count = skvt_pkg::POS_W'(used);
      pending_rsp.push_back(rs);
    endfunction

    // compare a response word with the oldest prediction
    function void check_response(skvt_pkg::rsp_t got);
      skvt_pkg::rsp_t want;
      if (pending_rsp.size() == 0) begin
        errors++;
        if (reports < 10) begin
          reports++;
          $display("unexpected response word %h", got);
        end
        return;
      end
      want = pending_rsp.pop_front();
      if (got !== want) begin
        errors++;
        if (reports < 10) begin
          reports++;
          $display("mismatch (expected/actual): status %0d/%0d key %h/%h data %h/%h",
                   want.status, got.status, want.key_out, got.key_out,
                   want.data_out, got.data_out);
          $display("  next position %0d/%0d entry count %0d/%0d",
                   want.next_position, got.next_position,
                   want.entry_count, got.entry_count);
        end
      end
    endfunction

    // predictions never answered count as failures
    function void flush_leftover();
      if (pending_rsp.size() != 0) begin
        errors += pending_rsp.size();
        $display("%0d response words never arrived", pending_rsp.size());
      end
    endfunction
  endclass

  logic           clk_i  = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start  = 1'b0;
  logic           busy;
  skvt_pkg::req_t req_i  = '0;
  logic           done_o;
  skvt_pkg::rsp_t rsp_o;

  kv_table_shadow              shadow = new();
  logic [skvt_pkg::KEY_W-1:0]  key_pool [POOL_N];
  int unsigned                 burst_left = 0;
  int unsigned                 sent_count = 0;
  int unsigned                 idle_cycles = 0;

  small_key_value_table uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // response checking
  always @(posedge clk_i) begin
    if (rst_ni && done_o) shadow.check_response(rsp_o);
  end

  // watchdog on cycles where no word moves in either direction
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic skvt_pkg::req_t make_req(skvt_pkg::op_e op,
                                              logic [skvt_pkg::KEY_W-1:0] k,
                                              logic [skvt_pkg::DATA_W-1:0] d,
                                              logic [skvt_pkg::POS_W-1:0] p);
    skvt_pkg::req_t r;
    r.operation = op;
    r.key       = k;
    r.data      = d;
    r.position  = p;
    return r;
  endfunction

  function automatic logic [skvt_pkg::DATA_W-1:0] rand_data();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // mostly keys already held or from the pool, so lookups and removes hit
  function automatic logic [skvt_pkg::KEY_W-1:0] pick_key();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40 && shadow.used > 0) return shadow.keys[$urandom_range(0, shadow.used - 1)];
    if (pick < 85) return key_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom;
  endfunction

  function automatic logic [skvt_pkg::POS_W-1:0] pick_pos();
    if ($urandom_range(0, 4) != 0) return skvt_pkg::POS_W'($urandom_range(0, shadow.used + 1));
    return skvt_pkg::POS_W'($urandom_range(0, 31));
  endfunction

  function automatic skvt_pkg::req_t mixed_word();
    int unsigned   pick;
    skvt_pkg::op_e op;
    pick = $urandom_range(0, 99);
    if (pick < 30) op = skvt_pkg::OP_LOOKUP;
    else if (pick < 60) op = skvt_pkg::OP_SET;
    else if (pick < 80) op = skvt_pkg::OP_REMOVE;
    else op = skvt_pkg::OP_READ;
    return make_req(op, pick_key(), rand_data(), pick_pos());
  endfunction

  // send one request word in bursts with random gaps between them
  task automatic send_word(input skvt_pkg::req_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy);
    shadow.note_request(w);
    sent_count++;
  endtask

  // hold off the sender until every predicted word has come back
  task automatic drain_results();
    start <= 1'b0;
    burst_left = 0;
    while (shadow.pending_rsp.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // stimulus
  initial begin : stimulus
    int unsigned mode;
    int unsigned n;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h0000_0001;
    key_pool[3] = 32'h8000_0000;
    for (int i = 4; i < POOL_N; i++) key_pool[i] = $urandom;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: lookup, remove and read all miss
    send_word(make_req(skvt_pkg::OP_LOOKUP, '0, '0, '0));
    send_word(make_req(skvt_pkg::OP_REMOVE, '0, '0, '0));
    send_word(make_req(skvt_pkg::OP_READ, '1, '1, '0));
    // extreme keys and values, then an in-place update
    send_word(make_req(skvt_pkg::OP_SET, '0, '1, '0));
    send_word(make_req(skvt_pkg::OP_SET, '1, '0, '1));
    send_word(make_req(skvt_pkg::OP_SET, '0, {32{2'b01}}, '0));
    send_word(make_req(skvt_pkg::OP_SET, 32'h8000_0000, {32{2'b10}}, '0));
    send_word(make_req(skvt_pkg::OP_LOOKUP, '1, '0, '0));
    send_word(make_req(skvt_pkg::OP_LOOKUP, '0, '0, '0));
    send_word(make_req(skvt_pkg::OP_READ, '0, '0, 5'd0));
    send_word(make_req(skvt_pkg::OP_READ, '0, '0, 5'd2));
    send_word(make_req(skvt_pkg::OP_READ, '0, '0, 5'd31));
    // remove moves the last entry into the freed slot
    send_word(make_req(skvt_pkg::OP_REMOVE, '0, '0, '0));
    send_word(make_req(skvt_pkg::OP_READ, '0, '0, 5'd0));
    send_word(make_req(skvt_pkg::OP_REMOVE, '0, '0, '0));
    // fill to capacity, then set on a full table
    while (shadow.used < skvt_pkg::CAPACITY) begin
      send_word(make_req(skvt_pkg::OP_SET,
                         {16'($urandom_range(0, 65535)), 16'(shadow.used + 16'h100)},
                         rand_data(), '0));
    end
    send_word(make_req(skvt_pkg::OP_SET, 32'h0000_0055, rand_data(), '0));
    send_word(make_req(skvt_pkg::OP_SET, '1, rand_data(), '0));
    send_word(make_req(skvt_pkg::OP_READ, '0, '0, 5'd16));
    send_word(make_req(skvt_pkg::OP_REMOVE, shadow.keys[skvt_pkg::CAPACITY-1], '0, '0));
    drain_results();

    // random episodes of well-formed sequences with some noise
    while (sent_count < ITEM_TARGET) begin
      mode = $urandom_range(0, 9);
      case (mode)
        0, 1: begin
          // push toward a full table
          n = $urandom_range(1, skvt_pkg::CAPACITY + 2);
          repeat (n) send_word(make_req(skvt_pkg::OP_SET,
                                        key_pool[$urandom_range(0, POOL_N - 1)],
                                        rand_data(), skvt_pkg::POS_W'($urandom)));
        end
        2: begin
          // walk every position up to the end
          for (int unsigned i = 0; i <= shadow.used; i++) begin
            send_word(make_req(skvt_pkg::OP_READ, $urandom, rand_data(),
                               skvt_pkg::POS_W'(i)));
          end
        end
        3: begin
          n = $urandom_range(1, 8);
          repeat (n) send_word(make_req(skvt_pkg::OP_REMOVE, pick_key(), rand_data(),
                                        skvt_pkg::POS_W'($urandom)));
        end
        4: begin
          // fully random words
          n = $urandom_range(1, 6);
          repeat (n) send_word(make_req(skvt_pkg::op_e'($urandom_range(0, 3)), $urandom,
                                        rand_data(),
                                        skvt_pkg::POS_W'($urandom_range(0, 31))));
        end
        default: begin
          n = $urandom_range(10, 40);
          repeat (n) send_word(mixed_word());
        end
      endcase
      if ($urandom_range(0, 11) == 0) drain_results();
    end

    // wait out the last responses, then report
    drain_results();
    repeat (END_WAIT) @(posedge clk_i);
    shadow.flush_leftover();
    if (shadow.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
